// ----- design/kfli_pkg.sv -----
// ---------------------------------------------------------------------------
// kfli_pkg: shared types and constants of the keyframe linear interpolator
// Word layouts, register map, item kinds and status codes.
// ---------------------------------------------------------------------------
package kfli_pkg;

	localparam int KEY_DEPTH_DEF = 64;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;
	localparam int KIU_W         = 7;
	localparam int FRAC_W        = 16;
	localparam int FACTOR_W      = FRAC_W + 1;
	localparam int COMPS         = 3;

	localparam logic [KIU_W-1:0]    KIU_RESET  = 7'd1;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;

	// register index as seen in paddr[PADDR_W-1:2]
	localparam logic [PADDR_W-3:0] REG_KEYS_IN_USE = 1'b0;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] ST_INTERP   = 2'd0;
	localparam logic [1:0] ST_SINGLE   = 2'd1;
	localparam logic [1:0] ST_ZERO_IVL = 2'd2;

	typedef logic [COMPS-1:0][31:0] kfli_vec_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  key_slot;
		logic [31:0] key_time;
		logic [31:0] key_x;
		logic [31:0] key_y;
		logic [31:0] key_z;
		logic [31:0] query_time;
	} kfli_in_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic [5:0]  segment;
		logic [1:0]  status;
	} kfli_out_t;

endpackage

// ----- design/kfli_ram.sv -----
// ---------------------------------------------------------------------------
// kfli_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module kfli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/keyframe_linear_interpolator.sv -----
// ---------------------------------------------------------------------------
// keyframe_linear_interpolator: key table with linear sampling
// Loads keys into a time RAM and a value RAM, and answers time queries by a
// linear segment search, a bit-serial factor division and a shared multiplier.
// ---------------------------------------------------------------------------
// Load: busy stays low, no result.
// Query, one key in use: S_ONE reads the value of key 0, S_ONE_CAP captures it, then done.
// Query, segment s: linear segment search, then the 16-step divider only when the
// factor needs it; one time RAM read per key scanned.
// Busy rises after accept and is low again when done is strobed; results cannot be stalled.
// Reset clears the sequencer and sets keys_in_use to 1; the key RAMs hold garbage.
module keyframe_linear_interpolator #(
	parameter int KEY_DEPTH = kfli_pkg::KEY_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  kfli_pkg::kfli_in_t             item,
	output logic                           done,
	output kfli_pkg::kfli_out_t            result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [kfli_pkg::PADDR_W-1:0]   paddr,
	input  logic [kfli_pkg::PDATA_W-1:0]   pwdata,
	output logic [kfli_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	import kfli_pkg::*;

	localparam int AW = $clog2(KEY_DEPTH);

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_ONE     = 13'b0000000000010,
		S_ONE_CAP = 13'b0000000000100,
		S_SRCH    = 13'b0000000001000,
		S_T1      = 13'b0000000010000,
		S_V1      = 13'b0000000100000,
		S_V2      = 13'b0000001000000,
		S_ABS     = 13'b0000010000000,
		S_DEC     = 13'b0000100000000,
		S_DIV     = 13'b0001000000000,
		S_DIFF    = 13'b0010000000000,
		S_MUL     = 13'b0100000000000,
		S_ADD     = 13'b1000000000000
	} state_t;

	state_t           state_q;
	logic [KIU_W-1:0] kiu_q;
	logic             done_q;
	logic             rd_vld_q;

	logic [31:0]         q_q;
	logic [AW-1:0]       last_q;
	logic [AW-1:0]       scan_q;
	logic [AW-1:0]       cand_q;
	logic [AW-1:0]       seg_q;
	logic [31:0]         t1_q;
	logic [31:0]         t2_q;
	kfli_vec_t           vs_q;
	kfli_vec_t           ve_q;
	logic signed [32:0]  num_q;
	logic signed [32:0]  den_q;
	logic [31:0]         an_q;
	logic [31:0]         ad_q;
	logic                den_zero_q;
	logic                same_q;
	logic [31:0]         rem_q;
	logic [FRAC_W-1:0]   quo_q;
	logic [3:0]          cnt_q;
	logic [FACTOR_W-1:0] f_q;
	logic [1:0]          comp_q;
	logic signed [32:0]  diff_q;
	logic signed [50:0]  prod_q;
	kfli_vec_t           res_q;
	logic [1:0]          status_q;

	logic          accept;
	logic          load_we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] t_raddr;
	logic [AW-1:0] v_raddr;
	logic [31:0]   t_rdata;
	kfli_vec_t     v_rdata;
	kfli_vec_t     v_wdata;
	logic [31:0]   n_keys;
	logic          cfg_wr;
	logic [32:0]   rem2;
	logic          rem_ge;

	assign accept  = start && !busy;
	assign load_we = accept && (item.kind == KIND_LOAD) && (32'(item.key_slot) < 32'(KEY_DEPTH));
	assign waddr   = AW'(item.key_slot);
	assign v_wdata = {item.key_z, item.key_y, item.key_x};

	// clamp keys_in_use to 1..KEY_DEPTH
	always_comb begin
		if (kiu_q == '0) begin
			n_keys = 32'd1;
		end else if (32'(kiu_q) > 32'(KEY_DEPTH)) begin
			n_keys = 32'(KEY_DEPTH);
		end else begin
			n_keys = 32'(kiu_q);
		end
	end

	always_comb begin
		t_raddr = scan_q;
		v_raddr = seg_q;
		unique case (state_q)
			S_T1:    t_raddr = seg_q;
			default: t_raddr = scan_q;
		endcase
		unique case (state_q)
			S_ONE:   v_raddr = '0;
			S_V1:    v_raddr = AW'(seg_q + 1'b1);
			default: v_raddr = seg_q;
		endcase
	end

	kfli_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (waddr),
		.wdata (item.key_time),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	kfli_ram #(.WIDTH(COMPS*32), .DEPTH(KEY_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_KEYS_IN_USE);
	assign prdata = (paddr[PADDR_W-1:2] == REG_KEYS_IN_USE) ? PDATA_W'(kiu_q) : '0;

	assign rem2   = {rem_q, 1'b0};
	assign rem_ge = rem2 >= {1'b0, ad_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kiu_q    <= KIU_RESET;
			done_q   <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				kiu_q <= pwdata[KIU_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					rd_vld_q <= 1'b0;
					if (accept && item.kind == KIND_QUERY) begin
						state_q <= (n_keys == 32'd1) ? S_ONE : S_SRCH;
					end
				end
				S_ONE:     state_q <= S_ONE_CAP;
				S_ONE_CAP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_SRCH: begin
					if (rd_vld_q && (q_q < t_rdata || cand_q == last_q)) begin
						state_q <= S_T1;
					end else begin
						rd_vld_q <= 1'b1;
					end
				end
				S_T1:  state_q <= S_V1;
				S_V1:  state_q <= S_V2;
				S_V2:  state_q <= S_ABS;
				S_ABS: state_q <= S_DEC;
				S_DEC: begin
					if (!den_zero_q && same_q && an_q < ad_q) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: state_q <= S_MUL;
				S_MUL:  state_q <= S_ADD;
				S_ADD: begin
					if (comp_q == 2'(COMPS - 1)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_DIFF;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				q_q    <= item.query_time;
				last_q <= AW'(n_keys - 32'd2);
				scan_q <= AW'(1);
				comp_q <= '0;
			end
			S_ONE_CAP: begin
				res_q    <= v_rdata;
				seg_q    <= '0;
				status_q <= ST_SINGLE;
			end
			S_SRCH: begin
				if (rd_vld_q && (q_q < t_rdata || cand_q == last_q)) begin
					seg_q <= cand_q;
					t2_q  <= t_rdata;
				end else begin
					// advance the scan: issue the next key, note its segment
					cand_q <= AW'(scan_q - 1'b1);
					scan_q <= AW'(scan_q + 1'b1);
				end
			end
			S_V1: begin
				t1_q <= t_rdata;
				vs_q <= v_rdata;
			end
			S_V2: begin
				ve_q  <= v_rdata;
				num_q <= $signed({1'b0, q_q}) - $signed({1'b0, t1_q});
				den_q <= $signed({1'b0, t2_q}) - $signed({1'b0, t1_q});
			end
			S_ABS: begin
				an_q       <= num_q[32] ? 32'(-num_q) : 32'(num_q);
				ad_q       <= den_q[32] ? 32'(-den_q) : 32'(den_q);
				den_zero_q <= den_q == '0;
				same_q     <= (num_q != '0) && (den_q != '0) && (num_q[32] == den_q[32]);
			end
			S_DEC: begin
				rem_q    <= an_q;
				cnt_q    <= 4'(FRAC_W - 1);
				status_q <= den_zero_q ? ST_ZERO_IVL : ST_INTERP;
				if (den_zero_q || !same_q) begin
					f_q <= '0;
				end else if (an_q >= ad_q) begin
					f_q <= FACTOR_ONE;
				end else begin
					f_q <= '0;
				end
			end
			S_DIV: begin
				rem_q <= rem_ge ? 32'(rem2 - {1'b0, ad_q}) : 32'(rem2);
				quo_q <= {quo_q[FRAC_W-2:0], rem_ge};
				cnt_q <= 4'(cnt_q - 1'b1);
				if (cnt_q == '0) begin
					f_q <= {1'b0, quo_q[FRAC_W-2:0], rem_ge};
				end
			end
			S_DIFF: begin
				diff_q <= $signed({ve_q[comp_q][31], ve_q[comp_q]})
					- $signed({vs_q[comp_q][31], vs_q[comp_q]});
			end
			S_MUL: begin
				prod_q <= $signed({1'b0, f_q}) * diff_q;
			end
			S_ADD: begin
				// arithmetic shift floors the scaled step
				res_q[comp_q] <= vs_q[comp_q] + 32'(prod_q >>> FRAC_W);
				comp_q        <= 2'(comp_q + 1'b1);
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

	assign result.out_x   = res_q[0];
	assign result.out_y   = res_q[1];
	assign result.out_z   = res_q[2];
	assign result.segment = 6'(seg_q);
	assign result.status  = status_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word strobed while sequencer busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result word strobed on two consecutive cycles");

	a_single_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_SINGLE) |-> result.segment == '0)
		else $error("single-key result with nonzero segment");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("sequencer left idle without a start");

endmodule
